### rtl/core/rte_pkg.sv
package rte_pkg;

   // Datapath width and register count of the architectural register file.
   localparam int XLEN     = 64;
   localparam int NUM_REGS = 32;
   localparam int REG_AW   = $clog2(NUM_REGS);
   localparam int SHAMT_W  = $clog2(XLEN);

   // Fixed field widths on the stream ports.
   localparam int ACTION_W = 2;
   localparam int INSTR_W  = 32;
   localparam int REG_IDX_W = 5;
   localparam int VALUE_W  = 64;
   localparam int FUNCT7_W = 7;
   localparam int FUNCT3_W = 3;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;

   // Request kinds.
   localparam logic [ACTION_W-1:0] ACT_EXEC  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // funct3 codes of the R-type group.
   localparam logic [FUNCT3_W-1:0] F3_ADD_SUB = 3'd0;
   localparam logic [FUNCT3_W-1:0] F3_SLL     = 3'd1;
   localparam logic [FUNCT3_W-1:0] F3_SLT     = 3'd2;
   localparam logic [FUNCT3_W-1:0] F3_SLTU    = 3'd3;
   localparam logic [FUNCT3_W-1:0] F3_XOR     = 3'd4;
   localparam logic [FUNCT3_W-1:0] F3_SRL_SRA = 3'd5;
   localparam logic [FUNCT3_W-1:0] F3_OR      = 3'd6;
   localparam logic [FUNCT3_W-1:0] F3_AND     = 3'd7;

   // funct7 codes that select the base or the alternate operation.
   localparam logic [FUNCT7_W-1:0] F7_BASE = 7'h00;
   localparam logic [FUNCT7_W-1:0] F7_ALT  = 7'h20;

   typedef logic [XLEN-1:0] xword_type;

   typedef struct packed {
      logic                 we;
      logic [REG_IDX_W-1:0] addr;
      xword_type            data;
   } rf_wr_type;

   typedef struct packed {
      logic                 re;
      logic [REG_IDX_W-1:0] addr_a;
      logic [REG_IDX_W-1:0] addr_b;
   } rf_rd_type;

   function automatic logic reg_in_range(input logic [REG_IDX_W-1:0] idx);
      return int'(idx) < NUM_REGS;
   endfunction

endpackage

### rtl/core/rte_regfile.sv
module rte_regfile import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  rf_rd_type rd,
   input  rf_wr_type wr,
   output xword_type rdata_a,
   output xword_type rdata_b
);

   xword_type             regs_ff [NUM_REGS];
   logic [NUM_REGS-1:0]   valid_ff;
   logic [NUM_REGS-1:0]   valid_in;
   xword_type             rdata_a_ff;
   xword_type             rdata_b_ff;
   logic [REG_AW-1:0]     widx;
   logic [REG_AW-1:0]     ridx_a;
   logic [REG_AW-1:0]     ridx_b;
   logic                  hit_a;
   logic                  hit_b;
   logic                  fwd_a;
   logic                  fwd_b;

   assign widx   = wr.addr[REG_AW-1:0];
   assign ridx_a = rd.addr_a[REG_AW-1:0];
   assign ridx_b = rd.addr_b[REG_AW-1:0];

   // An entry never written since reset reads as zero.
   assign hit_a = reg_in_range(rd.addr_a) && valid_ff[ridx_a];
   assign hit_b = reg_in_range(rd.addr_b) && valid_ff[ridx_b];

   // A write in the same cycle wins over the stored contents.
   assign fwd_a = wr.we && (wr.addr == rd.addr_a);
   assign fwd_b = wr.we && (wr.addr == rd.addr_b);

   always_comb begin
      valid_in = valid_ff;
      if (wr.we) begin
         valid_in[widx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         regs_ff[widx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.re) begin
         if (fwd_a) begin
            rdata_a_ff <= wr.data;
         end else if (!hit_a) begin
            rdata_a_ff <= '0;
         end else begin
            rdata_a_ff <= regs_ff[ridx_a];
         end
         if (fwd_b) begin
            rdata_b_ff <= wr.data;
         end else if (!hit_b) begin
            rdata_b_ff <= '0;
         end else begin
            rdata_b_ff <= regs_ff[ridx_b];
         end
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### rtl/core/rte_alu.sv
module rte_alu import rte_pkg::*; (
   input  logic [FUNCT3_W-1:0] funct3,
   input  logic [FUNCT7_W-1:0] funct7,
   input  xword_type           op_a,
   input  xword_type           op_b,
   output xword_type           result,
   output logic                known
);

   logic [SHAMT_W-1:0] shamt;

   assign shamt = op_b[SHAMT_W-1:0];

   always_comb begin
      result = '0;
      known  = 1'b1;
      case (funct3)
         F3_ADD_SUB: begin
            if (funct7 == F7_BASE) begin
               result = op_a + op_b;
            end else if (funct7 == F7_ALT) begin
               result = op_a - op_b;
            end else begin
               known = 1'b0;
            end
         end
         F3_SLL:  result = op_a << shamt;
         F3_SLT:  result = XLEN'($signed(op_a) < $signed(op_b));
         F3_SLTU: result = XLEN'(op_a < op_b);
         F3_XOR:  result = op_a ^ op_b;
         F3_SRL_SRA: begin
            if (funct7 == F7_BASE) begin
               result = op_a >> shamt;
            end else if (funct7 == F7_ALT) begin
               result = xword_type'($signed(op_a) >>> shamt);
            end else begin
               known = 1'b0;
            end
         end
         F3_OR:   result = op_a | op_b;
         F3_AND:  result = op_a & op_b;
         default: result = op_a & op_b;
      endcase
   end

endmodule

### rtl/core/rv64_rtype_execute.sv
// RV64I R-type execute unit with a directly loadable register file.
//
// Requests arrive on the req_ stream. req_tuser carries the kind of request:
// execute one R-type instruction, write a register directly, or read one.
// Every request produces exactly one response on the rsp_ stream, carrying
// the destination register, the value written or read, and a flag in
// rsp_tuser that is set when a register was actually updated.
//
// An accepted request reads its operands into the register file's output
// registers and enters the operand stage, then moves on into the response
// register. Throughput is one request per cycle while the receiver keeps
// rsp_tready high; a write made by one request is forwarded into the operand
// read of the next, so back-to-back dependent instructions need no bubble.
//
// Reset clears the valid bit of every register file entry, so all registers
// read as zero right after reset. When the receiver holds rsp_tready low, the
// response register keeps its contents, one more request can be taken into
// the operand stage, and then req_tready drops until the response is taken.
// A held request performs its register write only when it moves on.
module rv64_rtype_execute import rte_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [31:0] instruction, [36:32] reg_index, [100:37] write_value, rest zero
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // [1:0] action
   input  logic [ACTION_W-1:0]     req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [4:0] dest_index, [68:5] value, rest zero
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // [0] wrote
   output logic                    rsp_tuser
);

   // Request fields.
   logic [ACTION_W-1:0]  in_action;
   logic [INSTR_W-1:0]   in_instr;
   logic [REG_IDX_W-1:0] in_reg_index;
   logic [VALUE_W-1:0]   in_write_value;
   logic [REG_IDX_W-1:0] in_rs1;
   logic [REG_IDX_W-1:0] in_rs2;
   logic [REG_IDX_W-1:0] in_rd;
   logic [REG_IDX_W-1:0] in_dest;
   logic                 req_accept;

   // Operand stage.
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [ACTION_W-1:0]  s1_action_ff;
   logic [FUNCT7_W-1:0]  s1_funct7_ff;
   logic [FUNCT3_W-1:0]  s1_funct3_ff;
   logic [REG_IDX_W-1:0] s1_dest_ff;
   xword_type            s1_wval_ff;
   logic                 s1_advance;

   // Execute and register file.
   rf_rd_type            rf_rd;
   rf_wr_type            rf_wr;
   xword_type            rdata_a;
   xword_type            rdata_b;
   xword_type            alu_result;
   logic                 alu_known;
   logic                 wr_ok;
   xword_type            wr_data;
   xword_type            out_value;
   logic                 dest_ok;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [REG_IDX_W-1:0] rsp_dest_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_wrote_ff;

   assign in_action      = req_tuser;
   assign in_instr       = req_tdata[31:0];
   assign in_reg_index   = req_tdata[36:32];
   assign in_write_value = req_tdata[100:37];
   assign in_rs2         = in_instr[24:20];
   assign in_rs1         = in_instr[19:15];
   assign in_rd          = in_instr[11:7];

   always_comb begin
      case (in_action)
         ACT_EXEC:  in_dest = in_rd;
         ACT_WRITE: in_dest = in_reg_index;
         ACT_READ:  in_dest = in_reg_index;
         default:   in_dest = '0;
      endcase
   end

   // The operand stage moves on whenever the response register is free or
   // is being emptied in this cycle.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // Port A serves rs1 or, for a direct read, the requested register.
   assign rf_rd.re     = req_accept;
   assign rf_rd.addr_a = (in_action == ACT_READ) ? in_reg_index : in_rs1;
   assign rf_rd.addr_b = in_rs2;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= in_action;
         s1_funct7_ff <= in_instr[31:25];
         s1_funct3_ff <= in_instr[14:12];
         s1_dest_ff   <= in_dest;
         s1_wval_ff   <= in_write_value[XLEN-1:0];
      end
   end

   rte_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd      (rf_rd),
      .wr      (rf_wr),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   rte_alu u_alu (
      .funct3 (s1_funct3_ff),
      .funct7 (s1_funct7_ff),
      .op_a   (rdata_a),
      .op_b   (rdata_b),
      .result (alu_result),
      .known  (alu_known)
   );

   // x0 and registers beyond the file are never written.
   assign dest_ok = (s1_dest_ff != '0) && reg_in_range(s1_dest_ff);

   always_comb begin
      wr_ok     = 1'b0;
      wr_data   = '0;
      out_value = '0;
      case (s1_action_ff)
         ACT_EXEC: begin
            wr_ok   = alu_known && dest_ok;
            wr_data = alu_result;
         end
         ACT_WRITE: begin
            wr_ok   = dest_ok;
            wr_data = s1_wval_ff;
         end
         ACT_READ: begin
            out_value = rdata_a;
         end
         default: begin
            wr_ok = 1'b0;
         end
      endcase
      if (wr_ok) begin
         out_value = wr_data;
      end
   end

   assign rf_wr.we   = s1_advance && wr_ok;
   assign rf_wr.addr = s1_dest_ff;
   assign rf_wr.data = wr_data;

   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_dest_ff  <= s1_dest_ff;
         rsp_value_ff <= VALUE_W'(out_value);
         rsp_wrote_ff <= wr_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - REG_IDX_W){1'b0}}, rsp_value_ff, rsp_dest_ff};
   assign rsp_tuser  = rsp_wrote_ff;

   // A response that reports a write never names x0.
   a_wrote_not_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_dest_ff != '0)
      else $error("response reports a write to x0");

   // The register file is only written by a request leaving the operand stage.
   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      rf_wr.we |-> s1_valid_ff && (!rsp_valid_ff || rsp_tready))
      else $error("register write without the operand stage moving on");

   // Backpressure reaches the request side only with both stages occupied.
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("request side stalled while the pipeline has room");

   // An accepted request always occupies the operand stage next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost from the operand stage");

endmodule

### tb/testbench.sv
module testbench;
   import rte_pkg::*;

   // Opcode of the integer register-register group. The block does not decode
   // it, so random requests also carry other values in these bits.
   localparam logic [6:0] OPC_OP = 7'b0110011;

   // The request kind that the block takes and answers without any effect.
   localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

   // Cycles without any accepted request or response before the run is
   // declared hung. It lies well above the slowest legal request and the long
   // receiver hold-off.
   localparam int STALL_LIMIT = 2000;

   // Requests of the random part, sent in chunks with their own idling mode.
   localparam int CHUNK_COUNT = 12;
   localparam int CHUNK_SIZE  = 50;

   // What one response carries.
   typedef struct packed {
      logic [REG_IDX_W-1:0] dest;
      xword_type            value;
      logic                 wrote;
   } writeback_type;

   // One request as the sender offers it. Where known is set, want holds the
   // response read straight off the definition of the block; elsewhere the
   // response comes from execute_request.
   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [INSTR_W-1:0]   instr;
      logic [REG_IDX_W-1:0] idx;
      xword_type            wval;
      logic                 known;
      writeback_type        want;
   } stim_row_type;

   localparam xword_type ONES     = {XLEN{1'b1}};
   localparam xword_type SIGN_BIT = {1'b1, {(XLEN-1){1'b0}}};

   // The directed table. Registers loaded at its start: x1 all ones, x2 one,
   // x3 the sign bit alone, x30 0xff (its low six bits give a shift of 63).
   localparam int NUM_DIRECTED = 25;
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // Right after reset every register reads zero.
      '{ACT_READ,  32'h0, 5'd5,  64'h0,    1'b1, '{5'd5,  64'h0,    1'b0}},
      // A direct write to x0 is dropped.
      '{ACT_WRITE, 32'h0, 5'd0,  ONES,     1'b1, '{5'd0,  64'h0,    1'b0}},
      '{ACT_WRITE, 32'h0, 5'd1,  ONES,     1'b1, '{5'd1,  ONES,     1'b1}},
      '{ACT_WRITE, 32'h0, 5'd2,  64'h1,    1'b1, '{5'd2,  64'h1,    1'b1}},
      '{ACT_WRITE, 32'h0, 5'd3,  SIGN_BIT, 1'b1, '{5'd3,  SIGN_BIT, 1'b1}},
      '{ACT_WRITE, 32'h0, 5'd30, 64'hff,   1'b1, '{5'd30, 64'hff,   1'b1}},
      '{ACT_READ,  32'h0, 5'd1,  64'h0,    1'b1, '{5'd1,  ONES,     1'b0}},
      '{ACT_READ,  32'h0, 5'd0,  64'h0,    1'b1, '{5'd0,  64'h0,    1'b0}},
      // Every operation, some of them twice, checked against the predictor.
      '{ACT_EXEC, {F7_BASE, 5'd2, 5'd1, F3_ADD_SUB, 5'd4, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_ALT, 5'd1, 5'd2, F3_ADD_SUB, 5'd5, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd30, 5'd1, F3_SLL, 5'd6, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd7, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd2, 5'd3, F3_SLT, 5'd18, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd8, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd1, 5'd2, F3_SLTU, 5'd9, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd10, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd30, 5'd3, F3_SRL_SRA, 5'd11, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_ALT, 5'd30, 5'd3, F3_SRL_SRA, 5'd12, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd3, 5'd2, F3_OR, 5'd13, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      '{ACT_EXEC, {F7_BASE, 5'd3, 5'd1, F3_AND, 5'd14, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      // An unknown funct7 on add/sub or on the right shifts writes nothing.
      '{ACT_EXEC, {7'h01, 5'd2, 5'd1, F3_ADD_SUB, 5'd15, OPC_OP}, 5'd0, 64'h0,
        1'b1, '{5'd15, 64'h0, 1'b0}},
      '{ACT_EXEC, {7'h7f, 5'd30, 5'd3, F3_SRL_SRA, 5'd16, OPC_OP}, 5'd0, 64'h0,
        1'b1, '{5'd16, 64'h0, 1'b0}},
      // Destination x0 writes nothing.
      '{ACT_EXEC, {F7_BASE, 5'd2, 5'd1, F3_ADD_SUB, 5'd0, OPC_OP}, 5'd0, 64'h0,
        1'b1, '{5'd0, 64'h0, 1'b0}},
      // Other funct3 values ignore funct7.
      '{ACT_EXEC, {7'h7f, 5'd2, 5'd1, F3_XOR, 5'd17, OPC_OP}, 5'd0, 64'h0, 1'b0, '0},
      // The unused request kind is ignored, whatever its other fields hold.
      '{ACT_IGNORED, 32'hffff_ffff, 5'd31, ONES, 1'b1, '{5'd0, 64'h0, 1'b0}}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [31:0] instruction, [36:32] reg_index, [100:37] write_value, rest zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [1:0] action
   logic [ACTION_W-1:0]   req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [4:0] dest_index, [68:5] value, rest zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] wrote
   logic                  rsp_tuser;

   // Shadow of the register file; entry 0 is never written and stays zero.
   xword_type     gpr_copy [NUM_REGS];
   // Responses owed by the block, oldest first.
   writeback_type writebacks_due [$];

   int unsigned mismatches     = 0;
   int unsigned quiet_cycles   = 0;
   // Idling modes of the two sides, switched between phases by the sender.
   bit          tx_idle        = 1'b1;
   bit          rx_idle        = 1'b1;
   // A nonzero value asks the receiver for one long hold-off of that length.
   int unsigned hold_off_cycles = 0;

   rv64_rtype_execute i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is held at the start and never asserted again.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // ALU of the R-type group. Returns 0 for an encoding that writes nothing.
   // Shifts take the low six bits of the second operand.
   function automatic logic alu_result(input logic [FUNCT3_W-1:0] f3,
                                       input logic [FUNCT7_W-1:0] f7,
                                       input xword_type a, input xword_type b,
                                       output xword_type r);
      logic [SHAMT_W-1:0] shamt;
      shamt = b[SHAMT_W-1:0];
      r     = '0;
      case (f3)
         F3_ADD_SUB: begin
            if (f7 == F7_BASE) r = a + b;
            else if (f7 == F7_ALT) r = a - b;
            else return 1'b0;
         end
         F3_SLL:  r = a << shamt;
         F3_SLT:  r = ($signed(a) < $signed(b)) ? xword_type'(1) : '0;
         F3_SLTU: r = (a < b) ? xword_type'(1) : '0;
         F3_XOR:  r = a ^ b;
         F3_SRL_SRA: begin
            if (f7 == F7_BASE) r = a >> shamt;
            else if (f7 == F7_ALT) r = xword_type'($signed(a) >>> shamt);
            else return 1'b0;
         end
         F3_OR:   r = a | b;
         default: r = a & b;
      endcase
      return 1'b1;
   endfunction

   // Carries out one request on the shadow register file and returns the
   // response the block owes for it.
   function automatic writeback_type execute_request(input stim_row_type row);
      writeback_type        wb;
      xword_type            r;
      logic [REG_IDX_W-1:0] rd;
      wb = '0;
      case (row.action)
         ACT_EXEC: begin
            rd      = row.instr[11:7];
            wb.dest = rd;
            if (alu_result(row.instr[14:12], row.instr[31:25],
                           gpr_copy[row.instr[19:15]], gpr_copy[row.instr[24:20]], r)
                && rd != 0) begin
               gpr_copy[rd] = r;
               wb.value     = r;
               wb.wrote     = 1'b1;
            end
         end
         ACT_WRITE: begin
            wb.dest = row.idx;
            if (row.idx != 0) begin
               gpr_copy[row.idx] = row.wval;
               wb.value          = row.wval;
               wb.wrote          = 1'b1;
            end
         end
         ACT_READ: begin
            wb.dest  = row.idx;
            wb.value = gpr_copy[row.idx];
         end
         default: ;
      endcase
      return wb;
   endfunction

   // Random request. Most are instructions with a legal funct7, so that the
   // ALU paths are exercised; direct writes keep loading corner values into
   // the file, and a few carry odd funct7, opcode or request kind.
   function automatic stim_row_type random_row();
      stim_row_type row;
      int unsigned  pick;
      row       = '0;
      row.instr = $urandom;
      row.idx   = REG_IDX_W'($urandom);
      pick      = $urandom_range(7, 0);
      case (pick)
         0: row.wval = '0;
         1: row.wval = ONES;
         2: row.wval = SIGN_BIT;
         3: row.wval = ~SIGN_BIT;
         4: row.wval = xword_type'($urandom_range(70, 0));
         default: row.wval = {$urandom, $urandom};
      endcase
      pick = $urandom_range(19, 0);
      if (pick == 0) row.action = ACT_IGNORED;
      else if (pick <= 2) row.action = ACT_READ;
      else if (pick <= 6) row.action = ACT_WRITE;
      else row.action = ACT_EXEC;
      pick = $urandom_range(9, 0);
      if (pick < 5) row.instr[31:25] = F7_BASE;
      else if (pick < 9) row.instr[31:25] = F7_ALT;
      if ($urandom_range(7, 0) != 0) row.instr[6:0] = OPC_OP;
      return row;
   endfunction

   // Offers one request, after an optional gap, and records the response it
   // owes once the block takes it. tvalid stays high after acceptance so that
   // back-to-back requests never lower and raise it in the same step.
   task automatic send_request(input stim_row_type row);
      int unsigned   gap;
      writeback_type wb;
      gap = tx_idle ? $urandom_range(14, 0) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.action;
      req_tdata  <= {3'b000, row.wval, row.idx, row.instr};
      do @(posedge clock); while (!req_tready);
      wb = execute_request(row);
      writebacks_due.push_back(row.known ? row.want : wb);
   endtask

   // The sender stops and waits until the block has returned every response.
   task automatic drain_writebacks();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (writebacks_due.size() != 0);
   endtask

   // Receiver: before each response it draws a stall, or takes the long
   // hold-off when the sender has asked for one, then holds tready high
   // until a response is taken.
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(14, 0) : 0;
         if (hold_off_cycles != 0) begin
            gap             = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Response checker: every accepted response is matched, field by field,
   // against the oldest response still owed.
   always @(posedge clock) begin
      writeback_type got;
      writeback_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[4:0], rsp_tdata[68:5], rsp_tuser};
         if (writebacks_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: dest=%0d value=%h wrote=%b",
                        got.dest, got.value, got.wrote);
         end else begin
            want = writebacks_due.pop_front();
            if (got.dest !== want.dest || got.value !== want.value
                || got.wrote !== want.wrote) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response mismatch: expected dest=%0d value=%h wrote=%b",
                           want.dest, want.value, want.wrote);
                  $display("                   got      dest=%0d value=%h wrote=%b",
                           got.dest, got.value, got.wrote);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a response moves.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus: the directed table, then random chunks with changing idling
   // modes. One chunk runs against a long receiver hold-off with the sender
   // offering back to back, so the block fills and drops req_tready; between
   // some chunks the sender waits until every response has come back.
   initial begin
      int unsigned k;
      int unsigned n;
      for (k = 0; k < NUM_REGS; k++) gpr_copy[k] = '0;
      while (reset) @(posedge clock);

      for (k = 0; k < NUM_DIRECTED; k++) send_request(DIRECTED_ROWS[k]);
      drain_writebacks();

      for (k = 0; k < CHUNK_COUNT; k++) begin
         if (k == 0) begin
            // A stretch with no idling on either side.
            tx_idle = 1'b0;
            rx_idle = 1'b0;
         end else if (k == 3) begin
            tx_idle         = 1'b0;
            rx_idle         = 1'b1;
            hold_off_cycles = 90;
         end else begin
            tx_idle = $urandom_range(3, 0) != 0;
            rx_idle = $urandom_range(3, 0) != 0;
         end
         for (n = 0; n < CHUNK_SIZE; n++) send_request(random_row());
         if (k % 2 == 1) drain_writebacks();
      end

      drain_writebacks();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
